// File: rtl/dfr_pkg.sv
// Shared constants, types and round function for the DES Feistel round chain.
package dfr_pkg;

    localparam int ROUND_COUNT = 16;
    localparam int KEY_IDX_W   = 4;
    localparam int KEY_W       = 48;
    localparam int HALF_W      = 32;
    localparam int BLOCK_W     = 2 * HALF_W;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_BLOCK = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] data;
    } stage_t;

    localparam logic [5:0] EXPAND_MAP [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] PERM_MAP [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX [512] = '{
        4'd14,4'd0,4'd4,4'd15,4'd13,4'd7,4'd1,4'd4,4'd2,4'd14,4'd15,4'd2,4'd11,4'd13,4'd8,4'd1,
        4'd3,4'd10,4'd10,4'd6,4'd6,4'd12,4'd12,4'd11,4'd5,4'd9,4'd9,4'd5,4'd0,4'd3,4'd7,4'd8,
        4'd4,4'd15,4'd1,4'd12,4'd14,4'd8,4'd8,4'd2,4'd13,4'd4,4'd6,4'd9,4'd2,4'd1,4'd11,4'd7,
        4'd15,4'd5,4'd12,4'd11,4'd9,4'd3,4'd7,4'd14,4'd3,4'd10,4'd10,4'd0,4'd5,4'd6,4'd0,4'd13,

        4'd15,4'd3,4'd1,4'd13,4'd8,4'd4,4'd14,4'd7,4'd6,4'd15,4'd11,4'd2,4'd3,4'd8,4'd4,4'd14,
        4'd9,4'd12,4'd7,4'd0,4'd2,4'd1,4'd13,4'd10,4'd12,4'd6,4'd0,4'd9,4'd5,4'd11,4'd10,4'd5,
        4'd0,4'd13,4'd14,4'd8,4'd7,4'd10,4'd11,4'd1,4'd10,4'd3,4'd4,4'd15,4'd13,4'd4,4'd1,4'd2,
        4'd5,4'd11,4'd8,4'd6,4'd12,4'd7,4'd6,4'd12,4'd9,4'd0,4'd3,4'd5,4'd2,4'd14,4'd15,4'd9,

        4'd10,4'd13,4'd0,4'd7,4'd9,4'd0,4'd14,4'd9,4'd6,4'd3,4'd3,4'd4,4'd15,4'd6,4'd5,4'd10,
        4'd1,4'd2,4'd13,4'd8,4'd12,4'd5,4'd7,4'd14,4'd11,4'd12,4'd4,4'd11,4'd2,4'd15,4'd8,4'd1,
        4'd13,4'd1,4'd6,4'd10,4'd4,4'd13,4'd9,4'd0,4'd8,4'd6,4'd15,4'd9,4'd3,4'd8,4'd0,4'd7,
        4'd11,4'd4,4'd1,4'd15,4'd2,4'd14,4'd12,4'd3,4'd5,4'd11,4'd10,4'd5,4'd14,4'd2,4'd7,4'd12,

        4'd7,4'd13,4'd13,4'd8,4'd14,4'd11,4'd3,4'd5,4'd0,4'd6,4'd6,4'd15,4'd9,4'd0,4'd10,4'd3,
        4'd1,4'd4,4'd2,4'd7,4'd8,4'd2,4'd5,4'd12,4'd11,4'd1,4'd12,4'd10,4'd4,4'd14,4'd15,4'd9,
        4'd10,4'd3,4'd6,4'd15,4'd9,4'd0,4'd0,4'd6,4'd12,4'd10,4'd11,4'd1,4'd7,4'd13,4'd13,4'd8,
        4'd15,4'd9,4'd1,4'd4,4'd3,4'd5,4'd14,4'd11,4'd5,4'd12,4'd2,4'd7,4'd8,4'd2,4'd4,4'd14,

        4'd2,4'd14,4'd12,4'd11,4'd4,4'd2,4'd1,4'd12,4'd7,4'd4,4'd10,4'd7,4'd11,4'd13,4'd6,4'd1,
        4'd8,4'd5,4'd5,4'd0,4'd3,4'd15,4'd15,4'd10,4'd13,4'd3,4'd0,4'd9,4'd14,4'd8,4'd9,4'd6,
        4'd4,4'd11,4'd2,4'd8,4'd1,4'd12,4'd11,4'd7,4'd10,4'd1,4'd13,4'd14,4'd7,4'd2,4'd8,4'd13,
        4'd15,4'd6,4'd9,4'd15,4'd12,4'd0,4'd5,4'd9,4'd6,4'd10,4'd3,4'd4,4'd0,4'd5,4'd14,4'd3,

        4'd12,4'd10,4'd1,4'd15,4'd10,4'd4,4'd15,4'd2,4'd9,4'd7,4'd2,4'd12,4'd6,4'd9,4'd8,4'd5,
        4'd0,4'd6,4'd13,4'd1,4'd3,4'd13,4'd4,4'd14,4'd14,4'd0,4'd7,4'd11,4'd5,4'd3,4'd11,4'd8,
        4'd9,4'd4,4'd14,4'd3,4'd15,4'd2,4'd5,4'd12,4'd2,4'd9,4'd8,4'd5,4'd12,4'd15,4'd3,4'd10,
        4'd7,4'd11,4'd0,4'd14,4'd4,4'd1,4'd10,4'd7,4'd1,4'd6,4'd13,4'd0,4'd11,4'd8,4'd6,4'd13,

        4'd4,4'd13,4'd11,4'd0,4'd2,4'd11,4'd14,4'd7,4'd15,4'd4,4'd0,4'd9,4'd8,4'd1,4'd13,4'd10,
        4'd3,4'd14,4'd12,4'd3,4'd9,4'd5,4'd7,4'd12,4'd5,4'd2,4'd10,4'd15,4'd6,4'd8,4'd1,4'd6,
        4'd1,4'd6,4'd4,4'd11,4'd11,4'd13,4'd13,4'd8,4'd12,4'd1,4'd3,4'd4,4'd7,4'd10,4'd14,4'd7,
        4'd10,4'd9,4'd15,4'd5,4'd6,4'd0,4'd8,4'd15,4'd0,4'd14,4'd5,4'd2,4'd9,4'd3,4'd2,4'd12,

        4'd13,4'd1,4'd2,4'd15,4'd8,4'd13,4'd4,4'd8,4'd6,4'd10,4'd15,4'd3,4'd11,4'd7,4'd1,4'd4,
        4'd10,4'd12,4'd9,4'd5,4'd3,4'd6,4'd14,4'd11,4'd5,4'd0,4'd0,4'd14,4'd12,4'd9,4'd7,4'd2,
        4'd7,4'd2,4'd11,4'd1,4'd4,4'd14,4'd1,4'd7,4'd9,4'd4,4'd12,4'd10,4'd14,4'd8,4'd2,4'd13,
        4'd0,4'd15,4'd6,4'd12,4'd10,4'd9,4'd13,4'd0,4'd15,4'd3,4'd3,4'd5,4'd5,4'd6,4'd8,4'd11
    };

    function automatic logic [KEY_W-1:0] expand(input logic [HALF_W-1:0] half);
        logic [KEY_W-1:0] wide;
        wide = '0;
        for (int i = 0; i < KEY_W; i++)
        begin
            wide[KEY_W-1-i] = half[5'(HALF_W - int'(EXPAND_MAP[i]))];
        end
        return wide;
    endfunction

    function automatic logic [HALF_W-1:0] substitute(input logic [KEY_W-1:0] wide);
        logic [HALF_W-1:0] sout;
        logic [5:0]        six;
        sout = '0;
        for (int i = 0; i < 8; i++)
        begin
            six = wide[KEY_W-1-6*i -: 6];
            sout[HALF_W-1-4*i -: 4] = SBOX[9'(64 * i) + {3'b000, six}];
        end
        return sout;
    endfunction

    function automatic logic [HALF_W-1:0] permute(input logic [HALF_W-1:0] sout);
        logic [HALF_W-1:0] res;
        res = '0;
        for (int i = 0; i < HALF_W; i++)
        begin
            res[HALF_W-1-i] = sout[5'(HALF_W - int'(PERM_MAP[i]))];
        end
        return res;
    endfunction

    function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                 input logic [KEY_W-1:0]  subkey);
        return permute(substitute(expand(half) ^ subkey));
    endfunction

endpackage

// File: rtl/dfr_in_if.sv
// Input channel: valid/ready handshake carrying one load or block transaction.
interface dfr_in_if;
    import dfr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [KEY_IDX_W-1:0] subkey_index;
    logic [KEY_W-1:0]     subkey_value;
    logic [BLOCK_W-1:0]   data_block;

    modport source (output valid, output mode, output subkey_index, output subkey_value,
                    output data_block, input ready);
    modport sink   (input valid, input mode, input subkey_index, input subkey_value,
                    input data_block, output ready);
endinterface

// File: rtl/dfr_out_if.sv
// Output channel: valid/ready handshake carrying one result transaction.
interface dfr_out_if;
    import dfr_pkg::*;

    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] result_block;

    modport source (output valid, output result_block, input ready);
    modport sink   (input valid, input result_block, output ready);
endinterface

// File: rtl/dfr_cell.sv
// One Feistel round cell: holds its round subkey and one block stage.
module dfr_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      key_we,
    input  logic [dfr_pkg::KEY_W-1:0] key_value,
    input  dfr_pkg::stage_t           prev,
    output dfr_pkg::stage_t           next
);
    import dfr_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic               valid_reg;
    logic               valid_next;
    logic [BLOCK_W-1:0] data_reg;
    logic [BLOCK_W-1:0] data_next;
    logic [HALF_W-1:0]  left;
    logic [HALF_W-1:0]  right;

    assign left  = prev.data[BLOCK_W-1:HALF_W];
    assign right = prev.data[HALF_W-1:0];

    always_comb
    begin
        key_next   = key_we ? key_value : key_reg;
        valid_next = advance ? prev.valid : valid_reg;
        data_next  = data_reg;
        if (advance && prev.valid)
        begin
            data_next = {right, left ^ round_f(right, key_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign next.valid = valid_reg;
    assign next.data  = data_reg;
endmodule

// File: rtl/des_feistel_rounds.sv
// Sixteen-round DES Feistel chain: one round cell per round, one output register.
// A block transaction passes through the round cells in order and is then held in the output register.
// Blocks: a new block is accepted only after the previous one has left the round chain;
// load transactions are taken one per cycle while no block is in the chain and the output can move.
// Reset clears the stage and output valid flags; subkeys are undefined until loaded.
module des_feistel_rounds
(
    input  logic clk,
    input  logic rst_n,
    dfr_in_if.sink    item,
    dfr_out_if.source result
);
    import dfr_pkg::*;

    stage_t                 stage [ROUND_COUNT+1];
    logic [ROUND_COUNT-1:0] cell_valid;
    logic                   advance;
    logic                   accept;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [BLOCK_W-1:0]     out_data_reg;
    logic [BLOCK_W-1:0]     out_data_next;
    logic                   last_move;

    assign item.ready = !busy_reg && advance;
    assign accept     = item.valid && item.ready;
    assign advance    = !out_valid_reg || result.ready;

    assign stage[0].valid = accept && (item.mode == MODE_BLOCK);
    assign stage[0].data  = item.data_block;

    for (genvar k = 0; k < ROUND_COUNT; k++)
    begin : g_cell
        localparam logic [KEY_IDX_W-1:0] CELL_IDX = KEY_IDX_W'(k);

        dfr_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .key_we    (accept && (item.mode == MODE_LOAD) && (item.subkey_index == CELL_IDX)),
            .key_value (item.subkey_value),
            .prev      (stage[k]),
            .next      (stage[k+1])
        );

        assign cell_valid[k] = stage[k+1].valid;
    end

    assign last_move = stage[ROUND_COUNT].valid && advance;

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (stage[0].valid)
        begin
            busy_next = 1'b1;
        end
        else if (last_move)
        begin
            busy_next = 1'b0;
        end
        if (last_move)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {stage[ROUND_COUNT].data[HALF_W-1:0],
                              stage[ROUND_COUNT].data[BLOCK_W-1:HALF_W]};
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.result_block = out_data_reg;

`ifndef SYNTHESIS
    a_one_block: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_valid))
        else $error("more than one block in the round chain");

    a_busy_tracks_chain: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (|cell_valid))
        else $error("busy flag disagrees with the round chain");

    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        last_move |=> out_valid_reg)
        else $error("finished block not captured in the output register");

    a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (|cell_valid) |-> !accept)
        else $error("transaction accepted while a block is in flight");
`endif
endmodule
